FILE: sv/flacpbl_pkg.sv
// ----------------------------------------------------------------------------
// FLAC picture block locator package
// Parser phases, file constants and register map for the picture locator.
// ----------------------------------------------------------------------------
package flacpbl_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLKLEN_W = 24;
    localparam int unsigned PADDR_W = 3;

    // "fLaC" read as a big-endian word.
    localparam logic [WORD_W-1:0]   MAGIC_WORD       = 32'h664C_6143;
    localparam logic [6:0]          PICTURE_BLK_TYPE = 7'd6;
    localparam logic [WORD_W-1:0]   PREF_TYPE_RESET  = 32'd3;

    // Register index, taken from paddr[2].
    localparam logic                REG_PREFERRED_TYPE = 1'b0;

    typedef enum logic [13:0] {
        PH_MAGIC    = 14'h0001,
        PH_HEADER   = 14'h0002,
        PH_PTYPE    = 14'h0004,
        PH_MIMELEN  = 14'h0008,
        PH_MIMESKIP = 14'h0010,
        PH_DESCLEN  = 14'h0020,
        PH_DESCSKIP = 14'h0040,
        PH_WIDTH    = 14'h0080,
        PH_HEIGHT   = 14'h0100,
        PH_DEPTH    = 14'h0200,
        PH_COLORS   = 14'h0400,
        PH_DATALEN  = 14'h0800,
        PH_BLKSKIP  = 14'h1000,
        PH_DONE     = 14'h2000
    } phase_t;

endpackage

FILE: sv/flac_picture_block_locator.sv
// ----------------------------------------------------------------------------
// FLAC picture block locator
// Walks FLAC metadata one byte per unstalled cycle; reports picture data location.
// ----------------------------------------------------------------------------
// Throughput: one byte item per cycle while s_ready is high; the parser updates
// in the accept cycle. A result item is registered into the head register, or
// into the spare one while the head is held. The spare lets bytes flow on while
// a result waits; the input stalls only while two result items are waiting.
// Reset: synchronous, active low; parser state cleared and preferred type = 3.
// The parser also re-arms itself after every byte marked as final.
module flac_picture_block_locator
    import flacpbl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [WORD_W-1:0]   pwdata,
    output logic [WORD_W-1:0]   prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_final_byte,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_ok,
    output logic                m_is_flac,
    output logic                m_found,
    output logic [WORD_W-1:0]   m_picture_offset,
    output logic [WORD_W-1:0]   m_picture_size,
    output logic [WORD_W-1:0]   m_picture_kind,
    output logic [WORD_W-1:0]   m_mime_length
);

    typedef struct packed {
        logic               ok;
        logic               is_flac;
        logic               found;
        logic [WORD_W-1:0]  offset;
        logic [WORD_W-1:0]  size;
        logic [WORD_W-1:0]  kind;
        logic [WORD_W-1:0]  mime;
    } result_t;

    logic [WORD_W-1:0]   pref_type_reg;

    phase_t              phase_reg, phase_next;
    logic [WORD_W-1:0]   pos_reg, pos_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [1:0]          idx_reg, idx_next;
    logic [WORD_W-1:0]   skip_reg, skip_next;
    logic [BLKLEN_W-1:0] blk_len_reg, blk_len_next;
    logic [WORD_W-1:0]   blk_start_reg, blk_start_next;
    logic                last_blk_reg, last_blk_next;
    logic [WORD_W-1:0]   cur_type_reg, cur_type_next;
    logic [WORD_W-1:0]   cur_mime_reg, cur_mime_next;
    logic                fb_valid_reg, fb_valid_next;
    logic [WORD_W-1:0]   fb_offset_reg, fb_offset_next;
    logic [WORD_W-1:0]   fb_size_reg, fb_size_next;
    logic [WORD_W-1:0]   fb_type_reg, fb_type_next;
    logic [WORD_W-1:0]   fb_mime_reg, fb_mime_next;
    logic                sent_reg, sent_next;

    logic                m_valid_reg;
    logic                spare_valid_reg;
    result_t             head_reg;
    result_t             spare_reg;
    result_t             res_word;
    logic                m_pop;

    logic                s_fire;
    logic                cfg_write;

    logic                emit;
    logic                res_ok, res_is_flac, res_found;
    logic [WORD_W-1:0]   res_offset, res_size, res_kind, res_mime;
    logic                do_finish;

    logic [WORD_W-1:0]   pos_inc;
    logic [WORD_W-1:0]   acc_shift;
    logic                word_done;
    logic [WORD_W:0]     consumed;
    logic [BLKLEN_W:0]   remain;
    logic                overrun;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_PREFERRED_TYPE) ? pref_type_reg : '0;

    assign s_ready = !spare_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_pop   = m_valid_reg && m_ready;

    // Field helpers: the byte is shifted into the low end of the accumulator.
    assign pos_inc   = pos_reg + 32'd1;
    assign acc_shift = {acc_reg[WORD_W-9:0], s_data_byte};
    assign word_done = (idx_reg == 2'd3);

    // Bytes taken from the picture block so far; the top bit flags a wrap.
    assign consumed = {1'b0, pos_inc} - {1'b0, blk_start_reg};
    assign remain   = {1'b0, blk_len_reg} - {1'b0, consumed[BLKLEN_W-1:0]};
    assign overrun  = consumed[WORD_W] || (consumed[WORD_W-1:BLKLEN_W] != '0) ||
                      remain[BLKLEN_W];

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        skip_next      = skip_reg;
        blk_len_next   = blk_len_reg;
        blk_start_next = blk_start_reg;
        last_blk_next  = last_blk_reg;
        cur_type_next  = cur_type_reg;
        cur_mime_next  = cur_mime_reg;
        fb_valid_next  = fb_valid_reg;
        fb_offset_next = fb_offset_reg;
        fb_size_next   = fb_size_reg;
        fb_type_next   = fb_type_reg;
        fb_mime_next   = fb_mime_reg;
        sent_next      = sent_reg;

        emit        = 1'b0;
        do_finish   = 1'b0;
        res_ok      = 1'b0;
        res_is_flac = 1'b0;
        res_found   = 1'b0;
        res_offset  = '0;
        res_size    = '0;
        res_kind    = '0;
        res_mime    = '0;

        if (s_fire && !sent_reg) begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_MAGIC, PH_HEADER, PH_PTYPE, PH_MIMELEN, PH_DESCLEN,
                PH_WIDTH, PH_HEIGHT, PH_DEPTH, PH_COLORS, PH_DATALEN: begin
                    acc_next = acc_shift;
                    idx_next = idx_reg + 2'd1;
                end
                default: begin
                end
            endcase

            case (phase_reg)
                PH_MAGIC: begin
                    if (word_done) begin
                        if (acc_shift != MAGIC_WORD) begin
                            emit       = 1'b1;
                            res_ok     = 1'b1;
                            phase_next = PH_DONE;
                            sent_next  = 1'b1;
                        end else begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                PH_HEADER: begin
                    if (word_done) begin
                        last_blk_next  = acc_shift[WORD_W-1];
                        blk_len_next   = acc_shift[BLKLEN_W-1:0];
                        blk_start_next = pos_inc;
                        if (acc_shift[WORD_W-2:BLKLEN_W] == PICTURE_BLK_TYPE) begin
                            phase_next = PH_PTYPE;
                        end else if (acc_shift[BLKLEN_W-1:0] != '0) begin
                            skip_next  = {8'd0, acc_shift[BLKLEN_W-1:0]};
                            phase_next = PH_BLKSKIP;
                        end else if (acc_shift[WORD_W-1]) begin
                            do_finish = 1'b1;
                        end
                    end
                end
                PH_PTYPE: begin
                    if (word_done) begin
                        cur_type_next = acc_shift;
                        phase_next    = PH_MIMELEN;
                    end
                end
                PH_MIMELEN: begin
                    if (word_done) begin
                        cur_mime_next = acc_shift;
                        skip_next     = acc_shift;
                        phase_next    = (acc_shift != '0) ? PH_MIMESKIP : PH_DESCLEN;
                    end
                end
                PH_MIMESKIP: begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1) begin
                        phase_next = PH_DESCLEN;
                    end
                end
                PH_DESCLEN: begin
                    if (word_done) begin
                        skip_next  = acc_shift;
                        phase_next = (acc_shift != '0) ? PH_DESCSKIP : PH_WIDTH;
                    end
                end
                PH_DESCSKIP: begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1) begin
                        phase_next = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    if (word_done) begin
                        phase_next = PH_HEIGHT;
                    end
                end
                PH_HEIGHT: begin
                    if (word_done) begin
                        phase_next = PH_DEPTH;
                    end
                end
                PH_DEPTH: begin
                    if (word_done) begin
                        phase_next = PH_COLORS;
                    end
                end
                PH_COLORS: begin
                    if (word_done) begin
                        phase_next = PH_DATALEN;
                    end
                end
                PH_DATALEN: begin
                    if (word_done) begin
                        if ((acc_shift != '0) && (cur_type_reg == pref_type_reg)) begin
                            emit        = 1'b1;
                            res_ok      = 1'b1;
                            res_is_flac = 1'b1;
                            res_found   = 1'b1;
                            res_offset  = pos_inc;
                            res_size    = acc_shift;
                            res_kind    = cur_type_reg;
                            res_mime    = cur_mime_reg;
                            phase_next  = PH_DONE;
                            sent_next   = 1'b1;
                        end else begin
                            // Only the first picture with data is kept as fallback.
                            if ((acc_shift != '0) && !fb_valid_reg) begin
                                fb_valid_next  = 1'b1;
                                fb_offset_next = pos_inc;
                                fb_size_next   = acc_shift;
                                fb_type_next   = cur_type_reg;
                                fb_mime_next   = cur_mime_reg;
                            end
                            if (overrun) begin
                                do_finish = 1'b1;
                            end else if (remain[BLKLEN_W-1:0] != '0) begin
                                skip_next  = {8'd0, remain[BLKLEN_W-1:0]};
                                phase_next = PH_BLKSKIP;
                            end else if (last_blk_reg) begin
                                do_finish = 1'b1;
                            end else begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                end
                PH_BLKSKIP: begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1) begin
                        if (last_blk_reg) begin
                            do_finish = 1'b1;
                        end else begin
                            phase_next = PH_HEADER;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // End of file forces a result if none has gone out yet.
        if (s_fire && s_final_byte && !sent_next && !do_finish) begin
            if (phase_next == PH_MAGIC) begin
                emit = 1'b1;
            end else begin
                do_finish = 1'b1;
            end
        end

        if (do_finish) begin
            emit        = 1'b1;
            res_ok      = 1'b1;
            res_is_flac = 1'b1;
            res_found   = fb_valid_next;
            res_offset  = fb_valid_next ? fb_offset_next : '0;
            res_size    = fb_valid_next ? fb_size_next : '0;
            res_kind    = fb_valid_next ? fb_type_next : '0;
            res_mime    = fb_valid_next ? fb_mime_next : '0;
            phase_next  = PH_DONE;
            sent_next   = 1'b1;
        end

        if (s_fire && s_final_byte) begin
            phase_next     = PH_MAGIC;
            pos_next       = '0;
            acc_next       = '0;
            idx_next       = '0;
            skip_next      = '0;
            blk_len_next   = '0;
            blk_start_next = '0;
            last_blk_next  = 1'b0;
            cur_type_next  = '0;
            cur_mime_next  = '0;
            fb_valid_next  = 1'b0;
            fb_offset_next = '0;
            fb_size_next   = '0;
            fb_type_next   = '0;
            fb_mime_next   = '0;
            sent_next      = 1'b0;
        end
    end

    assign res_word = {res_ok, res_is_flac, res_found, res_offset, res_size,
                       res_kind, res_mime};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pref_type_reg   <= PREF_TYPE_RESET;
            phase_reg       <= PH_MAGIC;
            pos_reg         <= '0;
            acc_reg         <= '0;
            idx_reg         <= '0;
            skip_reg        <= '0;
            blk_len_reg     <= '0;
            blk_start_reg   <= '0;
            last_blk_reg    <= 1'b0;
            cur_type_reg    <= '0;
            cur_mime_reg    <= '0;
            fb_valid_reg    <= 1'b0;
            fb_offset_reg   <= '0;
            fb_size_reg     <= '0;
            fb_type_reg     <= '0;
            fb_mime_reg     <= '0;
            sent_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            spare_valid_reg <= 1'b0;
        end else begin
            if (cfg_write && (paddr[2] == REG_PREFERRED_TYPE)) begin
                pref_type_reg <= pwdata;
            end
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            acc_reg       <= acc_next;
            idx_reg       <= idx_next;
            skip_reg      <= skip_next;
            blk_len_reg   <= blk_len_next;
            blk_start_reg <= blk_start_next;
            last_blk_reg  <= last_blk_next;
            cur_type_reg  <= cur_type_next;
            cur_mime_reg  <= cur_mime_next;
            fb_valid_reg  <= fb_valid_next;
            fb_offset_reg <= fb_offset_next;
            fb_size_reg   <= fb_size_next;
            fb_type_reg   <= fb_type_next;
            fb_mime_reg   <= fb_mime_next;
            sent_reg      <= sent_next;
            // The spare only fills while the head is held, and no byte is taken
            // while it is full, so it never meets a new result item.
            if (m_pop || !m_valid_reg) begin
                if (spare_valid_reg) begin
                    m_valid_reg     <= 1'b1;
                    spare_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= emit;
                end
            end else if (emit) begin
                spare_valid_reg <= 1'b1;
            end
        end
    end

    // Result payloads; only loaded alongside a new or advancing result item.
    always_ff @(posedge aclk) begin
        if (m_pop || !m_valid_reg) begin
            if (spare_valid_reg) begin
                head_reg <= spare_reg;
            end else if (emit) begin
                head_reg <= res_word;
            end
        end else if (emit) begin
            spare_reg <= res_word;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_ok             = head_reg.ok;
    assign m_is_flac        = head_reg.is_flac;
    assign m_found          = head_reg.found;
    assign m_picture_offset = head_reg.offset;
    assign m_picture_size   = head_reg.size;
    assign m_picture_kind   = head_reg.kind;
    assign m_mime_length    = head_reg.mime;

    a_found_is_flac: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && head_reg.found) |-> (head_reg.ok && head_reg.is_flac))
        else $error("picture reported without a valid FLAC magic");

    a_found_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && head_reg.found) |-> (head_reg.size != '0))
        else $error("picture reported with zero data length");

    a_short_file_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !head_reg.ok) |-> (!head_reg.is_flac && !head_reg.found))
        else $error("short file result carries flags");

    a_sent_means_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sent_reg |-> (phase_reg == PH_DONE))
        else $error("result sent but parser not parked");

    a_field_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != 2'd0) |-> !(phase_reg == PH_BLKSKIP || phase_reg == PH_MIMESKIP ||
                                phase_reg == PH_DESCSKIP || phase_reg == PH_DONE))
        else $error("skip phase entered with a partial field");

    a_spare_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        spare_valid_reg |-> m_valid_reg)
        else $error("spare result held while the output is empty");

endmodule

FILE: tb/flac_locator_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FLAC picture locator result check
// Follows the byte stream and register writes of the locator and works out
// the one report that each file produces. Each result item is compared with
// the oldest report still due.
// ----------------------------------------------------------------------------
module flac_locator_check
    import flacpbl_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [WORD_W-1:0]   pwdata,
    input  logic                pready,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_final_byte,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_ok,
    input  logic                m_is_flac,
    input  logic                m_found,
    input  logic [WORD_W-1:0]   m_picture_offset,
    input  logic [WORD_W-1:0]   m_picture_size,
    input  logic [WORD_W-1:0]   m_picture_kind,
    input  logic [WORD_W-1:0]   m_mime_length,

    output int                  reports_due,
    output int                  mismatch_count
);

    typedef struct packed {
        logic               ok;
        logic               is_flac;
        logic               found;
        logic [WORD_W-1:0]  offset;
        logic [WORD_W-1:0]  data_size;
        logic [WORD_W-1:0]  kind;
        logic [WORD_W-1:0]  mime;
    } picture_report_t;

    picture_report_t        due_reports[$];
    int                     errors = 0;

    // Own copy of the parser state and of the preferred picture type.
    logic [WORD_W-1:0]      pref_kind;
    phase_t                 ph;
    logic [WORD_W-1:0]      pos;
    logic [WORD_W-1:0]      acc;
    logic [1:0]             nbytes;
    logic [WORD_W-1:0]      skip;
    logic [BLKLEN_W-1:0]    blk_len;
    logic [WORD_W-1:0]      blk_start;
    logic                   last_blk;
    logic [WORD_W-1:0]      cur_kind;
    logic [WORD_W-1:0]      cur_mime;
    logic                   keep_valid;
    logic [WORD_W-1:0]      keep_off;
    logic [WORD_W-1:0]      keep_size;
    logic [WORD_W-1:0]      keep_kind;
    logic [WORD_W-1:0]      keep_mime;
    logic                   done;

    function automatic void clear_parse();
        ph         = PH_MAGIC;
        pos        = '0;
        acc        = '0;
        nbytes     = '0;
        skip       = '0;
        blk_len    = '0;
        blk_start  = '0;
        last_blk   = 1'b0;
        cur_kind   = '0;
        cur_mime   = '0;
        keep_valid = 1'b0;
        keep_off   = '0;
        keep_size  = '0;
        keep_kind  = '0;
        keep_mime  = '0;
        done       = 1'b0;
    endfunction

    function automatic void add_report(logic ok, logic is_flac, logic found,
                                       logic [WORD_W-1:0] offset,
                                       logic [WORD_W-1:0] data_size,
                                       logic [WORD_W-1:0] kind,
                                       logic [WORD_W-1:0] mime);
        picture_report_t r;
        r.ok        = ok;
        r.is_flac   = is_flac;
        r.found     = found;
        // The picture fields read as zero whenever nothing was found.
        r.offset    = found ? offset : '0;
        r.data_size = found ? data_size : '0;
        r.kind      = found ? kind : '0;
        r.mime      = found ? mime : '0;
        due_reports.push_back(r);
    endfunction

    function automatic void finish_parse();
        add_report(1'b1, 1'b1, keep_valid, keep_off, keep_size, keep_kind, keep_mime);
        ph   = PH_DONE;
        done = 1'b1;
    endfunction

    function automatic logic shift_in(logic [7:0] value);
        acc    = {acc[WORD_W-9:0], value};
        nbytes = nbytes + 2'd1;
        return nbytes == 2'd0;
    endfunction

    function automatic void end_block();
        if (last_blk)
            finish_parse();
        else
            ph = PH_HEADER;
    endfunction

    function automatic void consume(logic [7:0] value);
        logic [WORD_W-1:0] used;
        pos = pos + 1;
        case (ph)
            PH_MAGIC: if (shift_in(value)) begin
                if (acc != MAGIC_WORD) begin
                    add_report(1'b1, 1'b0, 1'b0, '0, '0, '0, '0);
                    ph   = PH_DONE;
                    done = 1'b1;
                end else begin
                    ph = PH_HEADER;
                end
            end
            PH_HEADER: if (shift_in(value)) begin
                last_blk  = acc[31];
                blk_len   = acc[BLKLEN_W-1:0];
                blk_start = pos;
                if (acc[30:24] == PICTURE_BLK_TYPE) begin
                    ph = PH_PTYPE;
                end else if (blk_len != 0) begin
                    skip = {8'd0, blk_len};
                    ph   = PH_BLKSKIP;
                end else begin
                    end_block();
                end
            end
            PH_PTYPE: if (shift_in(value)) begin
                cur_kind = acc;
                ph       = PH_MIMELEN;
            end
            PH_MIMELEN: if (shift_in(value)) begin
                cur_mime = acc;
                skip     = acc;
                ph       = (acc != 0) ? PH_MIMESKIP : PH_DESCLEN;
            end
            PH_MIMESKIP: begin
                skip = skip - 1;
                if (skip == 0)
                    ph = PH_DESCLEN;
            end
            PH_DESCLEN: if (shift_in(value)) begin
                skip = acc;
                ph   = (acc != 0) ? PH_DESCSKIP : PH_WIDTH;
            end
            PH_DESCSKIP: begin
                skip = skip - 1;
                if (skip == 0)
                    ph = PH_WIDTH;
            end
            PH_WIDTH:  if (shift_in(value)) ph = PH_HEIGHT;
            PH_HEIGHT: if (shift_in(value)) ph = PH_DEPTH;
            PH_DEPTH:  if (shift_in(value)) ph = PH_COLORS;
            PH_COLORS: if (shift_in(value)) ph = PH_DATALEN;
            PH_DATALEN: if (shift_in(value)) begin
                // A preferred picture is reported before its block length is checked.
                if (acc != 0 && cur_kind == pref_kind) begin
                    add_report(1'b1, 1'b1, 1'b1, pos, acc, cur_kind, cur_mime);
                    ph   = PH_DONE;
                    done = 1'b1;
                end else begin
                    if (acc != 0 && !keep_valid) begin
                        keep_valid = 1'b1;
                        keep_off   = pos;
                        keep_size  = acc;
                        keep_kind  = cur_kind;
                        keep_mime  = cur_mime;
                    end
                    used = pos - blk_start;
                    if (pos < blk_start || used > {8'd0, blk_len}) begin
                        finish_parse();
                    end else begin
                        skip = {8'd0, blk_len} - used;
                        if (skip != 0)
                            ph = PH_BLKSKIP;
                        else
                            end_block();
                    end
                end
            end
            PH_BLKSKIP: begin
                skip = skip - 1;
                if (skip == 0)
                    end_block();
            end
            default: ;
        endcase
    endfunction

    function automatic void parse_byte(logic [7:0] value, logic last);
        if (!done)
            consume(value);
        if (last) begin
            if (!done) begin
                if (ph == PH_MAGIC)
                    add_report(1'b0, 1'b0, 1'b0, '0, '0, '0, '0);
                else
                    finish_parse();
            end
            clear_parse();
        end
    endfunction

    function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    function automatic void check_result();
        picture_report_t want;
        if (due_reports.size() == 0) begin
            errors++;
            $display("%0t: result item arrived with no report due", $time);
        end else begin
            want = due_reports.pop_front();
            check_field("ok", WORD_W'(want.ok), WORD_W'(m_ok));
            check_field("is_flac", WORD_W'(want.is_flac), WORD_W'(m_is_flac));
            check_field("found", WORD_W'(want.found), WORD_W'(m_found));
            check_field("picture_offset", want.offset, m_picture_offset);
            check_field("picture_size", want.data_size, m_picture_size);
            check_field("picture_kind", want.kind, m_picture_kind);
            check_field("mime_length", want.mime, m_mime_length);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parse();
            pref_kind = PREF_TYPE_RESET;
            due_reports.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_PREFERRED_TYPE)
                pref_kind = pwdata;
            // Bytes are parsed before results are taken, so a report is always queued
            // before the result item that carries it.
            if (s_valid && s_ready)
                parse_byte(s_data_byte, s_final_byte);
            if (m_valid && m_ready)
                check_result();
        end
        reports_due    <= due_reports.size();
        mismatch_count <= errors;
    end

endmodule

FILE: tb/tb_flac_picture_block_locator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FLAC picture block locator testbench
// Feeds whole files, mostly well-formed FLAC headers with random content and
// some truncated, malformed or noisy ones, under several preferred picture
// types. The byte sender works in bursts and the result side stalls on its
// own pattern; the check module beside the block judges every result item.
// ----------------------------------------------------------------------------
module tb_flac_picture_block_locator;
    import flacpbl_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 250;
    localparam int NUM_PHASES  = 6;

    logic                aclk = 1'b0;
    logic                aresetn;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [WORD_W-1:0]   pwdata;
    logic [WORD_W-1:0]   prdata;
    logic                pready;

    logic                s_valid;
    logic                s_ready;
    logic [7:0]          s_data_byte;
    logic                s_final_byte;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_ok;
    logic                m_is_flac;
    logic                m_found;
    logic [WORD_W-1:0]   m_picture_offset;
    logic [WORD_W-1:0]   m_picture_size;
    logic [WORD_W-1:0]   m_picture_kind;
    logic [WORD_W-1:0]   m_mime_length;

    int                  reports_due;
    int                  mismatch_count;

    logic [7:0]          file_q[$];
    logic [WORD_W-1:0]   pref_now;
    int                  burst_left  = 0;
    int                  rx_mode     = 0;
    int                  rx_span     = 0;
    int                  cycle_count = 0;

    flac_picture_block_locator dut (.*);

    flac_locator_check watch (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: spells of steady acceptance, random stalls and heavy stalls.
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_span <= $urandom_range(20, 200);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic add_word(input logic [WORD_W-1:0] w);
        file_q.push_back(w[31:24]);
        file_q.push_back(w[23:16]);
        file_q.push_back(w[15:8]);
        file_q.push_back(w[7:0]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) file_q.push_back(8'($urandom));
    endtask

    task automatic add_other_block(input logic is_last, output logic cut_short);
        logic [6:0]          btype;
        logic [BLKLEN_W-1:0] blen;
        cut_short = 1'b0;
        btype = 7'($urandom_range(0, 127));
        if (btype == PICTURE_BLK_TYPE)
            btype = 7'h7F;
        blen = 24'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 24'hFF_FFFF)
                                               : $urandom_range(0, 10));
        add_word({is_last, btype, blen});
        // A long block runs past the end of the file.
        if (blen > 12) begin
            add_noise(12);
            cut_short = 1'b1;
        end else begin
            add_noise(blen);
        end
    endtask

    task automatic add_picture(input logic is_last, output logic cut_short);
        logic [WORD_W-1:0] kind;
        logic [WORD_W-1:0] mime;
        logic [WORD_W-1:0] desc;
        logic [WORD_W-1:0] dlen;
        logic [WORD_W-1:0] fields;
        logic [WORD_W-1:0] natural_len;
        logic [WORD_W-1:0] declared;
        int                r;
        cut_short = 1'b0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: kind = pref_now;
            4, 5, 6:    kind = $urandom_range(0, 20);
            7:          kind = $urandom;
            8:          kind = '1;
            default:    kind = '0;
        endcase
        mime = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 5);
        desc = $urandom_range(0, 5);
        r = $urandom_range(0, 19);
        dlen = (r < 3) ? '0 : (r < 18) ? $urandom_range(1, 6) : (r == 18) ? $urandom : '1;
        fields = 32 + mime + desc;
        natural_len = (dlen <= 6) ? fields + dlen : fields;
        case ($urandom_range(0, 9))
            6:       declared = fields - $urandom_range(1, 31);
            7:       declared = natural_len + $urandom_range(1, 5);
            8:       declared = '0;
            9:       declared = $urandom_range(0, 24'hFF_FFFF);
            default: declared = natural_len;
        endcase
        if (mime > 5)
            declared = $urandom_range(0, 24'hFF_FFFF);
        add_word({is_last, PICTURE_BLK_TYPE, declared[BLKLEN_W-1:0]});
        add_word(kind);
        add_word(mime);
        // A long MIME string is cut off by the end of the file.
        if (mime > 5) begin
            add_noise($urandom_range(0, 12));
            cut_short = 1'b1;
            return;
        end
        add_noise(mime);
        add_word(desc);
        add_noise(desc);
        repeat (4) add_word($urandom);
        add_word(dlen);
        if (declared > fields) begin
            if (declared - fields > 12) begin
                add_noise(12);
                cut_short = 1'b1;
            end else begin
                add_noise(declared - fields);
            end
        end
    endtask

    task automatic cut_file(input int keep);
        while (file_q.size() > keep)
            void'(file_q.pop_back());
    endtask

    task automatic build_file();
        int   n;
        int   blocks;
        logic is_last;
        logic cut_short;
        file_q.delete();
        n = $urandom_range(0, 99);
        if (n < 6) begin
            // Too short to hold the magic.
            if ($urandom_range(0, 1) != 0)
                add_word(MAGIC_WORD);
            else
                add_noise(3);
            cut_file($urandom_range(1, 3));
        end else if (n < 14) begin
            add_word(MAGIC_WORD ^ (32'd1 << $urandom_range(0, 31)));
            add_noise($urandom_range(0, 6));
        end else if (n < 20) begin
            add_noise($urandom_range(1, 12));
        end else begin
            add_word(MAGIC_WORD);
            blocks = $urandom_range(1, 4);
            cut_short = 1'b0;
            for (int k = 0; k < blocks && !cut_short; k++) begin
                is_last = (k == blocks - 1) && ($urandom_range(0, 7) != 0);
                if ($urandom_range(0, 2) == 0)
                    add_other_block(is_last, cut_short);
                else
                    add_picture(is_last, cut_short);
            end
            if (!cut_short)
                add_noise($urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0)
                cut_file($urandom_range(1, file_q.size()));
        end
    endtask

    task automatic push_byte(input logic [7:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= value;
        s_final_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            push_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due != 0) @(posedge aclk);
        // The result register may still be busy.
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_preferred(input logic [WORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_PREFERRED_TYPE, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pref_now = value;
    endtask

    initial begin
        logic [WORD_W-1:0] pref_list[NUM_PHASES];
        int                bytes_sent;
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        s_data_byte  <= '0;
        s_final_byte <= 1'b0;
        pref_list[0] = PREF_TYPE_RESET;
        pref_list[1] = '0;
        pref_list[2] = '1;
        pref_list[3] = 32'd6;
        pref_list[4] = $urandom;
        pref_list[5] = 32'd1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_preferred(pref_list[p]);
            if (p == 0) begin
                // One byte, then three bytes of the magic: both end too early.
                file_q = '{8'h66};
                send_file();
                file_q = '{8'h66, 8'h4C, 8'h61};
                send_file();
                // Wrong magic, with a tail that must be ignored.
                file_q = '{8'h66, 8'h4C, 8'h61, 8'h00, 8'hFF, 8'h00};
                send_file();
                // Magic alone, ending on its fourth byte.
                file_q.delete();
                add_word(MAGIC_WORD);
                send_file();
                // Last block of the highest type and zero length.
                file_q.delete();
                add_word(MAGIC_WORD);
                add_word({1'b1, 7'h7F, 24'h0});
                send_file();
            end
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                build_file();
                send_file();
                bytes_sent += file_q.size();
            end
            wait_idle();
        end

        if (mismatch_count == 0 && reports_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
